@@ rtl/i2p_pkg.sv @@
// Shared types, codes and constants of the infix-to-postfix converter.
`timescale 1ns / 1ps

package i2p_pkg;

	localparam int STORE_DEPTH_DEF = 32;

	localparam int KIND_W = 2;
	localparam int OP_W   = 4;
	localparam int DATA_W = 32;
	localparam int PREC_W = 2;
	localparam int CAP_W  = 6;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// register index, taken from the word address of paddr
	localparam logic REG_CAP = 1'b0;

	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OPERAND  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd2;

	localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
	localparam logic [OP_W-1:0] OP_PLUS  = 4'd1;
	localparam logic [OP_W-1:0] OP_MINUS = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
	localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
	localparam logic [OP_W-1:0] OP_MOD   = 4'd5;
	localparam logic [OP_W-1:0] OP_EXP   = 4'd6;
	localparam logic [OP_W-1:0] OP_SQRT  = 4'd7;
	localparam logic [OP_W-1:0] OP_OPEN  = 4'd8;
	localparam logic [OP_W-1:0] OP_CLOSE = 4'd9;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		CLS_IGNORE,
		CLS_OPERAND,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OPER
	} cmd_cls_t;

	typedef struct packed {
		cmd_cls_t                 cls;
		logic [OP_W-1:0]          op;
		logic [PREC_W-1:0]        prec;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	function automatic logic [PREC_W-1:0] prec_of(input logic [OP_W-1:0] code);
		logic [PREC_W-1:0] p;
		unique case (code)
			OP_PLUS, OP_MINUS:       p = 2'd1;
			OP_MUL, OP_DIV, OP_MOD:  p = 2'd2;
			OP_EXP, OP_SQRT:         p = 2'd3;
			default:                 p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/i2p_front.sv @@
// Front end: accepts token requests and classifies them into queue commands.
`timescale 1ns / 1ps

module i2p_front (
	input  logic                                   tok_valid,
	output logic                                   tok_ready,
	input  logic [i2p_pkg::KIND_W-1:0]             token_kind,
	input  logic [i2p_pkg::OP_W-1:0]               operator_code,
	input  logic signed [i2p_pkg::DATA_W-1:0]      operand_value,
	input  logic                                   q_full,
	output logic                                   q_push,
	output i2p_pkg::cmd_t                          q_cmd
);

	i2p_pkg::cmd_cls_t cls;

	always_comb begin
		unique case (token_kind)
			i2p_pkg::KIND_OPERAND: cls = i2p_pkg::CLS_OPERAND;
			i2p_pkg::KIND_OPERATOR: begin
				if (operator_code == i2p_pkg::OP_OPEN) begin
					cls = i2p_pkg::CLS_OPEN;
				end else if (operator_code == i2p_pkg::OP_CLOSE) begin
					cls = i2p_pkg::CLS_CLOSE;
				end else begin
					cls = i2p_pkg::CLS_OPER;
				end
			end
			default: cls = i2p_pkg::CLS_IGNORE;
		endcase
	end

	assign tok_ready    = !q_full;
	assign q_push       = tok_valid && !q_full;
	assign q_cmd.cls    = cls;
	assign q_cmd.op     = operator_code;
	assign q_cmd.prec   = i2p_pkg::prec_of(operator_code);
	assign q_cmd.value  = operand_value;

endmodule

@@ rtl/i2p_cmd_fifo.sv @@
// Short command queue between the front end and the stack engine.
`timescale 1ns / 1ps

module i2p_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  i2p_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output i2p_pkg::cmd_t head_cmd
);

	i2p_pkg::cmd_t                entry_q [i2p_pkg::QUEUE_DEPTH];
	logic [i2p_pkg::QPTR_W:0]     wr_ptr_q;
	logic [i2p_pkg::QPTR_W:0]     rd_ptr_q;

	assign full = (wr_ptr_q[i2p_pkg::QPTR_W] != rd_ptr_q[i2p_pkg::QPTR_W]) &&
		(wr_ptr_q[i2p_pkg::QPTR_W-1:0] == rd_ptr_q[i2p_pkg::QPTR_W-1:0]);
	assign head_valid = (wr_ptr_q != rd_ptr_q);
	assign head_cmd   = entry_q[rd_ptr_q[i2p_pkg::QPTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q[i2p_pkg::QPTR_W-1:0]] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

@@ rtl/i2p_back.sv @@
// Back end: operator stack memory, pop sequencer and result output register.
`timescale 1ns / 1ps

module i2p_back #(
	parameter int STORE_DEPTH = i2p_pkg::STORE_DEPTH_DEF,
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1),
	localparam int ADDR_W = $clog2(STORE_DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               restart,
	input  logic [CNT_W-1:0]                   cap_eff,
	input  logic                               cmd_valid,
	input  i2p_pkg::cmd_t                      cmd,
	output logic                               cmd_pop,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic                               is_status,
	output logic [i2p_pkg::KIND_W-1:0]         out_kind,
	output logic [i2p_pkg::OP_W-1:0]           out_operator,
	output logic signed [i2p_pkg::DATA_W-1:0]  out_value,
	output logic                               status_code,
	output logic                               last,
	output logic [CNT_W-1:0]                   depth,
	output logic [CNT_W-1:0]                   ocnt
);

	localparam logic S_RUN  = 1'b0;
	localparam logic S_STAT = 1'b1;

	logic                      state_q, state_d;
	logic [CNT_W-1:0]          depth_q, depth_d;
	logic [CNT_W-1:0]          ocnt_q, ocnt_d;

	logic [i2p_pkg::OP_W-1:0]  stack_mem [STORE_DEPTH];
	logic [i2p_pkg::OP_W-1:0]  rd_q;
	logic                      byp_q;
	logic [i2p_pkg::OP_W-1:0]  byp_op_q;
	logic [i2p_pkg::OP_W-1:0]  tos;
	logic [CNT_W-1:0]          rd_wide;
	logic [ADDR_W-1:0]         raddr;

	logic                      we;
	logic                      out_free;
	logic                      store_full;
	logic [CNT_W:0]            used;
	logic                      close_go;
	logic                      oper_go;

	logic                               emit;
	logic                               o_st;
	logic [i2p_pkg::KIND_W-1:0]         o_kind;
	logic [i2p_pkg::OP_W-1:0]           o_op;
	logic signed [i2p_pkg::DATA_W-1:0]  o_val;
	logic                               o_code;

	logic                               res_valid_q;
	logic                               is_status_q;
	logic [i2p_pkg::KIND_W-1:0]         out_kind_q;
	logic [i2p_pkg::OP_W-1:0]           out_operator_q;
	logic signed [i2p_pkg::DATA_W-1:0]  out_value_q;
	logic                               status_code_q;

	// the top entry is read ahead into a register from the next depth; a fresh push bypasses the memory
	assign tos        = byp_q ? byp_op_q : rd_q;
	assign rd_wide    = depth_d - CNT_W'(1);
	assign raddr      = rd_wide[ADDR_W-1:0];

	assign out_free   = !res_valid_q || res_ready;
	assign used       = {1'b0, ocnt_q} + {1'b0, depth_q};
	assign store_full = (used >= {1'b0, cap_eff});
	assign close_go   = (depth_q != '0) && (tos != i2p_pkg::OP_OPEN);
	assign oper_go    = (depth_q != '0) && (cmd.prec < i2p_pkg::prec_of(tos));

	always_comb begin
		state_d = state_q;
		depth_d = depth_q;
		ocnt_d  = ocnt_q;
		we      = 1'b0;
		cmd_pop = 1'b0;
		emit    = 1'b0;
		o_st    = 1'b0;
		o_kind  = i2p_pkg::KIND_NONE;
		o_op    = i2p_pkg::OP_NONE;
		o_val   = '0;
		o_code  = i2p_pkg::ST_OK;
		if (restart) begin
			state_d = S_RUN;
			depth_d = '0;
			ocnt_d  = '0;
		end else if (out_free) begin
			unique case (state_q)
				S_STAT: begin
					emit    = 1'b1;
					o_st    = 1'b1;
					cmd_pop = 1'b1;
					state_d = S_RUN;
				end
				S_RUN: begin
					if (cmd_valid) begin
						emit = 1'b1;
						unique case (cmd.cls)
							i2p_pkg::CLS_OPERAND: begin
								if (store_full) begin
									o_st    = 1'b1;
									o_code  = i2p_pkg::ST_FULL;
									cmd_pop = 1'b1;
								end else begin
									o_kind  = i2p_pkg::KIND_OPERAND;
									o_val   = cmd.value;
									ocnt_d  = ocnt_q + 1'b1;
									state_d = S_STAT;
								end
							end
							i2p_pkg::CLS_OPEN: begin
								o_st    = 1'b1;
								cmd_pop = 1'b1;
								if (store_full) begin
									o_code = i2p_pkg::ST_FULL;
								end else begin
									we      = 1'b1;
									depth_d = depth_q + 1'b1;
								end
							end
							i2p_pkg::CLS_CLOSE: begin
								if (close_go) begin
									o_kind  = i2p_pkg::KIND_OPERATOR;
									o_op    = tos;
									depth_d = depth_q - 1'b1;
									ocnt_d  = ocnt_q + 1'b1;
								end else begin
									// drop the matching bracket, if any
									o_st    = 1'b1;
									cmd_pop = 1'b1;
									if (depth_q != '0) begin
										depth_d = depth_q - 1'b1;
									end
								end
							end
							i2p_pkg::CLS_OPER: begin
								if (oper_go) begin
									o_kind  = i2p_pkg::KIND_OPERATOR;
									o_op    = tos;
									depth_d = depth_q - 1'b1;
									ocnt_d  = ocnt_q + 1'b1;
								end else begin
									o_st    = 1'b1;
									cmd_pop = 1'b1;
									if (store_full) begin
										o_code = i2p_pkg::ST_FULL;
									end else begin
										we      = 1'b1;
										depth_d = depth_q + 1'b1;
									end
								end
							end
							default: begin
								o_st    = 1'b1;
								cmd_pop = 1'b1;
							end
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			stack_mem[depth_q[ADDR_W-1:0]] <= cmd.op;
		end
		rd_q     <= stack_mem[raddr];
		byp_q    <= we;
		byp_op_q <= cmd.op;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			is_status_q    <= o_st;
			out_kind_q     <= o_kind;
			out_operator_q <= o_op;
			out_value_q    <= o_val;
			status_code_q  <= o_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			depth_q     <= '0;
			ocnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			ocnt_q  <= ocnt_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign is_status    = is_status_q;
	assign out_kind     = out_kind_q;
	assign out_operator = out_operator_q;
	assign out_value    = out_value_q;
	assign status_code  = status_code_q;
	assign last         = is_status_q;
	assign depth        = depth_q;
	assign ocnt         = ocnt_q;

endmodule

@@ rtl/infix_to_postfix_converter_core.sv @@
// Top level of the shunting-yard infix-to-postfix converter.
`timescale 1ns / 1ps

// Usage:
//   Token requests enter on tok_valid/tok_ready with token_kind, operator_code
//   and operand_value. Results leave on res_valid/res_ready; every request
//   yields zero or more emitted tokens (operands or popped operators) and then
//   exactly one status item with is_status and last high and status_code set
//   (store full when an operand or push did not fit).
//   Flow: a request passes the command queue and then the output register before
//   its first result is valid. The stack engine produces one result per cycle
//   while the receiver does not stall, and a request yields 1 to STORE_DEPTH + 1
//   results in the back end; the pop loop over the operator stack sets this
//   figure.
//   A two-entry command queue lets the front accept requests while the back
//   end is still popping, and the output register holds a result while the
//   receiver stalls; the back end then waits and the queue fills, after which
//   tok_ready drops.
//   Configuration: an APB write of capacity_in_use at byte address 0 restarts
//   the conversion (stack and output count go to zero). Capacities beyond
//   STORE_DEPTH act as STORE_DEPTH.
//   Reset: capacity 32, stack and counts empty; the stack memory needs no
//   clearing pass, so requests are taken as soon as reset is released.
module infix_to_postfix_converter_core #(
	parameter int STORE_DEPTH = i2p_pkg::STORE_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// APB configuration port
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [i2p_pkg::APB_ADDR_W-1:0]          paddr,
	input  logic [i2p_pkg::APB_DATA_W-1:0]          pwdata,
	output logic [i2p_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                    pready,
	// token requests
	input  logic                                    tok_valid,
	output logic                                    tok_ready,
	input  logic [i2p_pkg::KIND_W-1:0]              token_kind,
	input  logic [i2p_pkg::OP_W-1:0]                operator_code,
	input  logic signed [i2p_pkg::DATA_W-1:0]       operand_value,
	// results
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output logic                                    is_status,
	output logic [i2p_pkg::KIND_W-1:0]              out_kind,
	output logic [i2p_pkg::OP_W-1:0]                out_operator,
	output logic signed [i2p_pkg::DATA_W-1:0]       out_value,
	output logic                                    status_code,
	output logic                                    last
);

	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	logic [i2p_pkg::CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]           cap_eff;
	logic                       cfg_wr;
	logic                       reg_idx;

	logic                       q_push;
	logic                       q_full;
	logic                       q_pop;
	logic                       q_valid;
	i2p_pkg::cmd_t              q_in;
	i2p_pkg::cmd_t              q_head;

	logic [CNT_W-1:0]           depth;
	logic [CNT_W-1:0]           ocnt;

	// Register decode: word index from the byte address.
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (reg_idx == i2p_pkg::REG_CAP);
	assign prdata  = (reg_idx == i2p_pkg::REG_CAP) ?
		{{(i2p_pkg::APB_DATA_W - i2p_pkg::CAP_W){1'b0}}, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= i2p_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[i2p_pkg::CAP_W-1:0];
		end
	end

	// Clamp the capacity to the physical store.
	assign cap_eff = (int'(cap_q) > STORE_DEPTH) ? CNT_W'(STORE_DEPTH) : CNT_W'(cap_q);

	i2p_front u_front (
		.tok_valid     (tok_valid),
		.tok_ready     (tok_ready),
		.token_kind    (token_kind),
		.operator_code (operator_code),
		.operand_value (operand_value),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_in)
	);

	i2p_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (q_head)
	);

	i2p_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (cfg_wr),
		.cap_eff      (cap_eff),
		.cmd_valid    (q_valid),
		.cmd          (q_head),
		.cmd_pop      (q_pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.is_status    (is_status),
		.out_kind     (out_kind),
		.out_operator (out_operator),
		.out_value    (out_value),
		.status_code  (status_code),
		.last         (last),
		.depth        (depth),
		.ocnt         (ocnt)
	);

`ifndef SYNTHESIS
	// Stacked plus emitted tokens never exceed the usable store.
	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, depth} + {1'b0, ocnt}) <= {1'b0, cap_eff})
		else $error("token store holds more than its capacity");

	// Retiring a command always leaves a status item in the output register.
	a_retire_status: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (res_valid && is_status && last))
		else $error("command retired without a status item");

	// Emitted tokens carry no status and are never marked last.
	a_token_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !is_status) |-> (!last && (status_code == i2p_pkg::ST_OK)))
		else $error("emitted token carries status bits");
`endif

endmodule

@@ tb/tb_top.sv @@
// Testbench for the infix-to-postfix converter: token streams checked against a shunting-yard predictor.
`timescale 1ns / 1ps

module tb_top;
	import i2p_pkg::*;

	localparam int DEPTH       = STORE_DEPTH_DEF;
	localparam int RAND_ITEMS  = 300;
	localparam int CYCLE_LIMIT = 250000;

	localparam logic [APB_ADDR_W-1:0] ADDR_CAP   = 3'd0;
	// word 1 holds no register: writes there must change nothing
	localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = 3'd4;
	localparam logic [KIND_W-1:0]     KIND_RSVD  = 2'd3;
	localparam logic [OP_W-1:0]       OP_TOP     = 4'd15;

	typedef struct {
		logic [KIND_W-1:0]        kind;
		logic [OP_W-1:0]          code;
		logic signed [DATA_W-1:0] value;
	} token_t;

	typedef struct {
		logic                     is_stat;
		logic [KIND_W-1:0]        kind;
		logic [OP_W-1:0]          code;
		logic signed [DATA_W-1:0] value;
		logic                     stat;
		logic                     is_last;
	} rpn_item_t;

	// receiver stall styles
	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_BEAT, RX_LONG} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]    paddr = '0;
	logic [APB_DATA_W-1:0]    pwdata = '0;
	logic [APB_DATA_W-1:0]    prdata;
	logic                     pready;

	logic                     tok_valid = 1'b0;
	logic                     tok_ready;
	logic [KIND_W-1:0]        token_kind = '0;
	logic [OP_W-1:0]          operator_code = '0;
	logic signed [DATA_W-1:0] operand_value = '0;

	logic                     res_valid;
	logic                     res_ready = 1'b0;
	logic                     is_status;
	logic [KIND_W-1:0]        out_kind;
	logic [OP_W-1:0]          out_operator;
	logic signed [DATA_W-1:0] out_value;
	logic                     status_code;
	logic                     last;

	// token requests waiting for the driver, and results still to arrive
	token_t    tok_q[$];
	rpn_item_t rpn_q[$];

	// predictor state: operator stack, emitted count and capacity
	logic [OP_W-1:0]  op_stack [DEPTH];
	int unsigned      stk_depth = 0;
	int unsigned      out_count = 0;
	logic [CAP_W-1:0] cap_reg = CAP_RESET;

	logic     tok_taken = 1'b0;
	bit       tok_eager = 1'b0;
	rx_mode_t rx_mode = RX_BEAT;

	int n_queued = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_full = 0;
	int n_pops = 0;
	int n_phases = 0;
	int n_fail = 0;
	int n_cycles = 0;

	infix_to_postfix_converter_core #(
		.STORE_DEPTH(DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.tok_valid    (tok_valid),
		.tok_ready    (tok_ready),
		.token_kind   (token_kind),
		.operator_code(operator_code),
		.operand_value(operand_value),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.is_status    (is_status),
		.out_kind     (out_kind),
		.out_operator (out_operator),
		.out_value    (out_value),
		.status_code  (status_code),
		.last         (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [1:0] op_rank(input logic [OP_W-1:0] code);
		case (code)
			OP_PLUS, OP_MINUS:      return 2'd1;
			OP_MUL, OP_DIV, OP_MOD: return 2'd2;
			OP_EXP, OP_SQRT:        return 2'd3;
			default:                return 2'd0;
		endcase
	endfunction

	task automatic expect_item(input logic st, input logic [KIND_W-1:0] kind,
			input logic [OP_W-1:0] code, input logic signed [DATA_W-1:0] value,
			input logic stat);
		rpn_item_t it;
		it.is_stat = st;
		it.kind    = kind;
		it.code    = code;
		it.value   = value;
		it.stat    = stat;
		// only the status item closes a request
		it.is_last = st;
		rpn_q.push_back(it);
	endtask

	// move the top of the stack to the output
	task automatic pop_operator();
		stk_depth--;
		out_count++;
		n_pops++;
		expect_item(1'b0, KIND_OPERATOR, op_stack[stk_depth], '0, ST_OK);
	endtask

	// Work out every result of one token request and advance the predictor.
	task automatic convert_token(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] code,
			input logic signed [DATA_W-1:0] value);
		int unsigned room;
		logic        full;
		logic [1:0]  rank;
		logic        st_code;
		room = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		// a pop keeps stack plus output constant, so the fill test holds throughout
		full = (out_count + stk_depth >= room);
		st_code = ST_OK;
		if (kind == KIND_OPERAND) begin
			if (full) begin
				st_code = ST_FULL;
			end else begin
				out_count++;
				expect_item(1'b0, KIND_OPERAND, OP_NONE, value, ST_OK);
			end
		end else if (kind == KIND_OPERATOR) begin
			if (code == OP_CLOSE) begin
				// flush down to the nearest open bracket and drop it; empty all if unmatched
				while (stk_depth > 0 && op_stack[stk_depth - 1] != OP_OPEN)
					pop_operator();
				if (stk_depth > 0)
					stk_depth--;
			end else begin
				if (code != OP_OPEN) begin
					rank = op_rank(code);
					while (stk_depth > 0 && rank < op_rank(op_stack[stk_depth - 1]))
						pop_operator();
				end
				if (full) begin
					st_code = ST_FULL;
				end else begin
					op_stack[stk_depth] = code;
					stk_depth++;
				end
			end
		end
		if (st_code == ST_FULL)
			n_full++;
		expect_item(1'b1, KIND_NONE, OP_NONE, '0, st_code);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return -32'sd1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_tok(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] code,
			input logic signed [DATA_W-1:0] value);
		token_t t;
		t.kind  = kind;
		t.code  = code;
		t.value = value;
		tok_q.push_back(t);
		// ignored kinds do not count toward the item budget
		if (kind == KIND_OPERAND || kind == KIND_OPERATOR)
			n_queued++;
	endtask

	// One well-formed infix expression with random nesting; don't-care fields carry junk.
	task automatic add_expr();
		int open_n;
		int terms;
		open_n = 0;
		terms = $urandom_range(1, 6);
		for (int t = 0; t < terms; t++) begin
			if (t > 0)
				add_tok(KIND_OPERATOR, OP_W'($urandom_range(OP_PLUS, OP_EXP)), $urandom);
			while (open_n < 3 && $urandom_range(0, 3) == 0) begin
				add_tok(KIND_OPERATOR, OP_OPEN, $urandom);
				open_n++;
			end
			if ($urandom_range(0, 5) == 0)
				add_tok(KIND_OPERATOR, OP_SQRT, $urandom);
			add_tok(KIND_OPERAND, OP_W'($urandom_range(0, 15)), rand_value());
			while (open_n > 0 && $urandom_range(0, 2) == 0) begin
				add_tok(KIND_OPERATOR, OP_CLOSE, $urandom);
				open_n--;
			end
		end
		while (open_n > 0) begin
			add_tok(KIND_OPERATOR, OP_CLOSE, $urandom);
			open_n--;
		end
	endtask

	// Hold until every request is taken and every result is back, then let the pipe drain.
	task automatic wait_idle();
		while (tok_q.size() != 0 || tok_valid || rpn_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write, then read the capacity back through the same port.
	task automatic write_capacity(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		logic [APB_DATA_W-1:0] readback;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		// register took the write at the last edge; restart the predictor to match
		if (addr == ADDR_CAP) begin
			cap_reg   = data[CAP_W-1:0];
			stk_depth = 0;
			out_count = 0;
		end
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_CAP;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== {{(APB_DATA_W - CAP_W){1'b0}}, cap_reg}) begin
			$error("capacity_in_use: expected %0d, got %0d", cap_reg, readback);
			n_fail++;
		end
	endtask

	// ------------------------------------------------------------------
	// Token driver: bursts of requests separated by random gaps
	// ------------------------------------------------------------------

	always @(negedge clk) begin : drive_tokens
		token_t nxt;
		int     gap_left;
		int     burst_left;
		if (!arst_n) begin
			tok_valid <= 1'b0;
		end else if (!tok_valid || tok_taken) begin
			// the slot is free: idle out the gap or present the next request
			if (gap_left > 0) begin
				gap_left--;
				tok_valid <= 1'b0;
			end else if (tok_q.size() > 0) begin
				nxt = tok_q.pop_front();
				tok_valid     <= 1'b1;
				token_kind    <= nxt.kind;
				operator_code <= nxt.code;
				operand_value <= nxt.value;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					if (tok_eager || $urandom_range(0, 2) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, 9);
				end
			end else begin
				tok_valid <= 1'b0;
			end
		end
		// else hold valid and payload until the request is taken
	end

	// ------------------------------------------------------------------
	// Result receiver: stall pattern chosen per phase
	// ------------------------------------------------------------------

	always @(negedge clk) begin : drive_ready
		int rx_tick;
		rx_tick++;
		case (rx_mode)
			RX_ALWAYS: res_ready <= 1'b1;
			RX_COIN:   res_ready <= ($urandom_range(0, 9) < 7);
			RX_BEAT:   res_ready <= (rx_tick % 5 != 2);
			default:   res_ready <= (rx_tick % 16 >= 10);
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: predict on every taken request, check every taken result
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin : watch
		rpn_item_t want;
		tok_taken <= tok_valid && tok_ready;
		if (arst_n) begin
			if (tok_valid && tok_ready) begin
				n_accepted++;
				convert_token(token_kind, operator_code, operand_value);
			end
			if (res_valid && res_ready) begin
				n_results++;
				if (rpn_q.size() == 0) begin
					$error("result with nothing expected: is_status %0d kind %0d op %0d value %0d",
						is_status, out_kind, out_operator, out_value);
					n_fail++;
				end else begin
					want = rpn_q.pop_front();
					check_field("is_status", want.is_stat, is_status);
					check_field("out_kind", want.kind, out_kind);
					check_field("out_operator", want.code, out_operator);
					check_field("out_value", want.value, out_value);
					check_field("status_code", want.stat, status_code);
					check_field("last", want.is_last, last);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", n_cycles, rpn_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, directed cases, then random phases
	// ------------------------------------------------------------------

	initial begin : sequencer
		int unsigned goal;
		int unsigned cap;
		int          pick;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// read back the reset capacity through a write to the empty word
		write_capacity(ADDR_SPARE, 32'd5);

		// walk every operator through one bracketed run in a store of 13
		write_capacity(ADDR_CAP, 32'd13);
		add_tok(KIND_OPERAND, OP_NONE, 32'sh7fffffff);
		add_tok(KIND_OPERATOR, OP_PLUS, '0);
		add_tok(KIND_OPERATOR, OP_OPEN, '0);
		add_tok(KIND_OPERAND, OP_NONE, 32'sh80000000);
		add_tok(KIND_OPERATOR, OP_MINUS, '0);
		add_tok(KIND_OPERATOR, OP_MUL, '0);
		add_tok(KIND_OPERATOR, OP_DIV, '0);
		add_tok(KIND_OPERATOR, OP_MOD, '0);
		add_tok(KIND_OPERATOR, OP_EXP, '0);
		add_tok(KIND_OPERATOR, OP_SQRT, '0);
		add_tok(KIND_OPERAND, OP_NONE, -32'sd1);
		// unknown and out-of-range codes rank lowest: flush to the bracket, then stack
		add_tok(KIND_OPERATOR, OP_NONE, '0);
		add_tok(KIND_OPERATOR, OP_TOP, '1);
		add_tok(KIND_OPERATOR, OP_CLOSE, '0);
		// unknown kinds are dropped
		add_tok(KIND_NONE, OP_PLUS, 32'sd5);
		add_tok(KIND_RSVD, OP_OPEN, 32'sd7);
		// unmatched close empties the stack
		add_tok(KIND_OPERATOR, OP_CLOSE, '0);
		wait_idle();

		// a write to the empty word must not restart: the store is one short of full
		write_capacity(ADDR_SPARE, 32'd40);
		add_tok(KIND_OPERAND, OP_NONE, 32'sd1);
		add_tok(KIND_OPERAND, OP_NONE, 32'sd2);
		wait_idle();

		// store of one: one operand fits, then every push is refused
		write_capacity(ADDR_CAP, 32'd1);
		add_tok(KIND_OPERAND, OP_NONE, 32'sd3);
		add_tok(KIND_OPERAND, OP_NONE, 32'sd4);
		add_tok(KIND_OPERATOR, OP_PLUS, '0);
		add_tok(KIND_OPERATOR, OP_OPEN, '0);
		add_tok(KIND_OPERATOR, OP_CLOSE, '0);
		wait_idle();

		// zero capacity refuses every operand and every push
		write_capacity(ADDR_CAP, 32'd0);
		add_tok(KIND_OPERAND, OP_NONE, 32'sd9);
		add_tok(KIND_OPERATOR, OP_MUL, '0);
		add_tok(KIND_OPERATOR, OP_CLOSE, '0);

		// random phases: restart with a new capacity, then stream mostly well-formed input
		goal = n_queued + RAND_ITEMS;
		while (n_queued < goal) begin
			wait_idle();
			tok_eager = ($urandom_range(0, 3) == 0);
			rx_mode   = rx_mode_t'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0:       cap = 63;
				1:       cap = 33;
				2:       cap = 32;
				3:       cap = $urandom_range(1, 6);
				4:       cap = $urandom_range(0, 63);
				default: cap = $urandom_range(20, 40);
			endcase
			write_capacity(ADDR_CAP, cap);
			n_phases++;
			cap = n_queued + $urandom_range(15, 40);
			while (n_queued < cap) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					add_expr();
					// often finish with a stray close, which flushes the stack down to any open bracket
					if ($urandom_range(0, 1) == 0)
						add_tok(KIND_OPERATOR, OP_CLOSE, $urandom);
				end else if (pick == 7) begin
					add_tok(KIND_W'($urandom_range(0, 3)), OP_W'($urandom_range(0, 15)),
						$urandom);
				end else if (pick == 8) begin
					add_tok(KIND_OPERATOR, OP_CLOSE, $urandom);
				end else begin
					add_tok(KIND_OPERATOR, OP_OPEN, $urandom);
				end
			end
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (rpn_q.size() != 0) begin
			$error("%0d expected results never arrived", rpn_q.size());
			n_fail++;
		end
		$display("covered %0d token requests over %0d random capacity settings, %0d results checked",
			n_accepted, n_phases, n_results);
		$display("store-full refusals %0d, operators moved from stack to output %0d",
			n_full, n_pops);
		if (n_fail == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/i2p_pkg.sv
rtl/i2p_front.sv
rtl/i2p_cmd_fifo.sv
rtl/i2p_back.sv
rtl/infix_to_postfix_converter_core.sv
tb/tb_top.sv
